@@ design/hsl2rgb_pkg.sv @@
// Shared types and constants for the HSL to RGB converter.
// Pixel structs for both channels and the default fraction width.
// No dependencies.
package hsl2rgb_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned HueBits         = 16;
  localparam int unsigned ChanBits        = 8;

  typedef struct packed {
    logic [HueBits-1:0] hue;
    logic [HueBits-1:0] saturation;
    logic [HueBits-1:0] lightness;
  } hsl_pix_t;

  typedef struct packed {
    logic [ChanBits-1:0] red;
    logic [ChanBits-1:0] green;
    logic [ChanBits-1:0] blue;
  } rgb_pix_t;

endpackage

@@ design/hsl2rgb_norm.sv @@
// Input scaling, two pipeline stages: hue to a fraction of a turn,
// saturation and lightness divided by full scale (65535) into fixed point.
// Depends on hsl2rgb_pkg.
module hsl2rgb_norm #(
  parameter int unsigned FracBits = hsl2rgb_pkg::FracBitsDefault
) (
  input  logic                     clk_i,
  input  logic [1:0]               en_i,
  input  hsl2rgb_pkg::hsl_pix_t    pix_i,
  output logic [FracBits-1:0]      h_o,
  output logic [FracBits:0]        s_o,
  output logic [FracBits:0]        l_o
);
  import hsl2rgb_pkg::*;

  localparam int unsigned W         = HueBits + FracBits;
  localparam int unsigned RW        = W + 2;
  localparam int unsigned DivShift  = 16;
  localparam int unsigned RemBits   = 18;
  localparam int unsigned FullScale = 65535;

  logic [W-1:0]              hw;
  logic [1:0][W-1:0]         a;
  logic [1:0][FracBits:0]    q0;
  logic [1:0][RW-1:0]        rf;
  logic [1:0][RemBits-1:0]   r;
  logic [1:0][FracBits:0]    qc;

  logic [FracBits-1:0]       h1_q;
  logic [1:0][FracBits:0]    q0_q;
  logic [1:0][RemBits-1:0]   r_q;
  logic [FracBits-1:0]       h2_q;
  logic [1:0][FracBits:0]    sl_q;

  // x/65535 ~ x>>16 + x>>32, short by at most two; remainder fixes it
  always_comb begin
    hw   = {pix_i.hue, {FracBits{1'b0}}};
    a[0] = {pix_i.saturation, {FracBits{1'b0}}};
    a[1] = {pix_i.lightness, {FracBits{1'b0}}};
    for (int i = 0; i < 2; i++) begin
      q0[i] = (FracBits+1)'(a[i] >> DivShift) + (FracBits+1)'(a[i] >> (2 * DivShift));
      rf[i] = RW'(a[i]) - (RW'(q0[i]) << DivShift) + RW'(q0[i]);
      r[i]  = rf[i][RemBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      h1_q <= hw[W-1:HueBits];
      q0_q <= q0;
      r_q  <= r;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (r_q[i] >= RemBits'(2 * FullScale)) begin
        qc[i] = q0_q[i] + (FracBits+1)'(2);
      end else if (r_q[i] >= RemBits'(FullScale)) begin
        qc[i] = q0_q[i] + (FracBits+1)'(1);
      end else begin
        qc[i] = q0_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      h2_q <= h1_q;
      sl_q <= qc;
    end
  end

  assign h_o = h2_q;
  assign s_o = sl_q[0];
  assign l_o = sl_q[1];

endmodule

@@ design/hsl2rgb_qp.sv @@
// Two stages: product L*S, then the q and p levels and the three hue
// positions (hue plus a third, hue, hue minus a third).
// Depends on hsl2rgb_pkg.
module hsl2rgb_qp #(
  parameter int unsigned FracBits = hsl2rgb_pkg::FracBitsDefault
) (
  input  logic                       clk_i,
  input  logic [1:0]                 en_i,
  input  logic [FracBits-1:0]        h_i,
  input  logic [FracBits:0]          s_i,
  input  logic [FracBits:0]          l_i,
  output logic [FracBits:0]          p_o,
  output logic [FracBits:0]          q_o,
  output logic [2:0][FracBits-1:0]   t_o
);
  import hsl2rgb_pkg::*;

  localparam longint unsigned OneL  = 64'd1 << FracBits;
  localparam logic [FracBits:0]   One   = (FracBits+1)'(OneL);
  localparam logic [FracBits:0]   Half  = (FracBits+1)'(OneL >> 1);
  localparam logic [FracBits-1:0] Third = FracBits'((OneL + 64'd1) / 64'd3);

  logic [2*FracBits+1:0]     prod;
  logic [FracBits:0]         ls_q;
  logic [FracBits:0]         s3_q;
  logic [FracBits:0]         l3_q;
  logic [FracBits-1:0]       h3_q;

  logic [FracBits+1:0]       qraw;
  logic [FracBits:0]         qv;
  logic [FracBits+1:0]       two_l;
  logic [FracBits+1:0]       praw;
  logic [FracBits:0]         pv;
  logic [FracBits:0]         p_q;
  logic [FracBits:0]         q_q;
  logic [2:0][FracBits-1:0]  t_q;

  assign prod = (2*FracBits+2)'(l_i) * (2*FracBits+2)'(s_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ls_q <= prod[2*FracBits:FracBits];
      s3_q <= s_i;
      l3_q <= l_i;
      h3_q <= h_i;
    end
  end

  always_comb begin
    if (l3_q < Half) begin
      qraw = (FracBits+2)'(l3_q) + (FracBits+2)'(ls_q);
    end else begin
      qraw = (FracBits+2)'(l3_q) + (FracBits+2)'(s3_q) - (FracBits+2)'(ls_q);
    end
    qv    = (qraw > (FracBits+2)'(One)) ? One : qraw[FracBits:0];
    two_l = {l3_q, 1'b0};
    if (two_l < (FracBits+2)'(qv)) begin
      praw = '0;
    end else begin
      praw = two_l - (FracBits+2)'(qv);
    end
    pv = (praw > (FracBits+2)'(One)) ? One : praw[FracBits:0];
    if (pv > qv) begin
      pv = qv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q    <= pv;
      q_q    <= qv;
      t_q[0] <= h3_q + Third;
      t_q[1] <= h3_q;
      t_q[2] <= h3_q - Third;
    end
  end

  assign p_o = p_q;
  assign q_o = q_q;
  assign t_o = t_q;

endmodule

@@ design/hsl2rgb_ramp.sv @@
// One color channel, three stages: ramp segment and slope factor,
// slope multiply, then scale by 255 with saturation at 255.
// Depends on hsl2rgb_pkg.
module hsl2rgb_ramp #(
  parameter int unsigned FracBits = hsl2rgb_pkg::FracBitsDefault
) (
  input  logic                               clk_i,
  input  logic [2:0]                         en_i,
  input  logic [FracBits:0]                  p_i,
  input  logic [FracBits:0]                  q_i,
  input  logic [FracBits-1:0]                t_i,
  output logic [hsl2rgb_pkg::ChanBits-1:0]   chan_o
);
  import hsl2rgb_pkg::*;

  typedef enum logic [1:0] {
    SegRise  = 2'd0,
    SegHoldQ = 2'd1,
    SegFall  = 2'd2,
    SegHoldP = 2'd3
  } ramp_seg_e;

  localparam longint unsigned OneL      = 64'd1 << FracBits;
  localparam logic [FracBits-1:0] Sixth     = FracBits'((OneL + 64'd3) / 64'd6);
  localparam logic [FracBits-1:0] Half      = FracBits'(OneL >> 1);
  localparam logic [FracBits-1:0] TwoThirds = FracBits'((64'd2 * OneL + 64'd1) / 64'd3);
  localparam int unsigned MW = FracBits + 3;
  localparam int unsigned PW = 2 * FracBits + 4;
  localparam int unsigned VW = FracBits + 2;
  localparam int unsigned SW = VW + ChanBits;
  localparam logic [ChanBits-1:0] ChanMax = '1;

  ramp_seg_e             seg;
  logic [FracBits-1:0]   fall;
  logic [MW-1:0]         m;
  logic [FracBits:0]     base;

  logic [FracBits:0]     d_q;
  logic [MW-1:0]         m_q;
  logic [FracBits:0]     base_q;

  logic [PW-1:0]         prod;
  logic [PW-1:0]         vsum;
  logic [VW-1:0]         v_q;

  logic [SW-1:0]         scaled;
  logic [SW-FracBits-1:0] sc_int;
  logic [ChanBits-1:0]   chan_q;

  always_comb begin
    if (t_i < Sixth) begin
      seg = SegRise;
    end else if (t_i < Half) begin
      seg = SegHoldQ;
    end else if (t_i < TwoThirds) begin
      seg = SegFall;
    end else begin
      seg = SegHoldP;
    end
    fall = TwoThirds - t_i;
    case (seg)
      SegRise: begin
        m    = (MW'(t_i) << 2) + (MW'(t_i) << 1);
        base = p_i;
      end
      SegHoldQ: begin
        m    = '0;
        base = q_i;
      end
      SegFall: begin
        m    = (MW'(fall) << 2) + (MW'(fall) << 1);
        base = p_i;
      end
      default: begin
        m    = '0;
        base = p_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d_q    <= q_i - p_i;
      m_q    <= m;
      base_q <= base;
    end
  end

  assign prod = PW'(d_q) * PW'(m_q);
  assign vsum = PW'(base_q) + (prod >> FracBits);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      v_q <= vsum[VW-1:0];
    end
  end

  assign scaled = {v_q, {ChanBits{1'b0}}} - SW'(v_q);
  assign sc_int = scaled[SW-1:FracBits];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      chan_q <= (sc_int > (SW-FracBits)'(ChanMax)) ? ChanMax : sc_int[ChanBits-1:0];
    end
  end

  assign chan_o = chan_q;

endmodule

@@ design/hsl_to_rgb_converter_unit.sv @@
// HSL to RGB converter top level: seven-stage pipeline with stage valids.
// Instantiates hsl2rgb_norm, hsl2rgb_qp and three hsl2rgb_ramp channels.
// Depends on hsl2rgb_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o | in_pix_i  (hue, sat, light)
//   out     | output    | out_valid_o / out_stall_i | out_pix_o (red, green, blue)
//
// One pixel per cycle sustained while out_stall_i stays low. The datapath
// stages are scale, divide fixup, L*S multiply, q/p, segment, slope multiply and
// 255 scale. Reset clears the stage valids only. An out stall holds the
// output stage; earlier stages keep moving until the bubbles are filled,
// and in_stall_o rises only when every stage holds a pixel.
module hsl_to_rgb_converter_unit #(
  parameter int unsigned FracBits = hsl2rgb_pkg::FracBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  hsl2rgb_pkg::hsl_pix_t   in_pix_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output hsl2rgb_pkg::rgb_pix_t   out_pix_o
);
  import hsl2rgb_pkg::*;

  localparam int unsigned NumStages = 7;

  logic [NumStages-1:0]        valid_q;
  logic [NumStages-1:0]        valid_d;
  logic [NumStages-1:0]        en;
  logic [NumStages-1:0]        src;

  logic [FracBits-1:0]         h;
  logic [FracBits:0]           s;
  logic [FracBits:0]           l;
  logic [FracBits:0]           p;
  logic [FracBits:0]           q;
  logic [2:0][FracBits-1:0]    t;
  logic [2:0][ChanBits-1:0]    chan;

  // a stage may load when empty or when its contents move on
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    src = {valid_q[NumStages-2:0], in_valid_i};
    for (int k = 0; k < NumStages; k++) begin
      valid_d[k] = en[k] ? src[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NumStages-1];

  hsl2rgb_norm #(.FracBits(FracBits)) u_norm (
    .clk_i (clk_i),
    .en_i  (en[1:0]),
    .pix_i (in_pix_i),
    .h_o   (h),
    .s_o   (s),
    .l_o   (l)
  );

  hsl2rgb_qp #(.FracBits(FracBits)) u_qp (
    .clk_i (clk_i),
    .en_i  (en[3:2]),
    .h_i   (h),
    .s_i   (s),
    .l_i   (l),
    .p_o   (p),
    .q_o   (q),
    .t_o   (t)
  );

  for (genvar c = 0; c < 3; c++) begin : g_chan
    hsl2rgb_ramp #(.FracBits(FracBits)) u_ramp (
      .clk_i  (clk_i),
      .en_i   (en[6:4]),
      .p_i    (p),
      .q_i    (q),
      .t_i    (t[c]),
      .chan_o (chan[c])
    );
  end

  always_comb begin
    out_pix_o.red   = chan[0];
    out_pix_o.green = chan[1];
    out_pix_o.blue  = chan[2];
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while a pipeline stage is empty");

  a_no_out_stall_no_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled without output backpressure");

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted transfer did not enter first stage");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NumStages-2] && en[NumStages-1]) |=> out_valid_o)
    else $error("pixel lost between last two stages");
`endif

endmodule
